[sv/pcbn_pkg.sv]
package pcbn_pkg;

    localparam int DEF_COORD_WIDTH = 24;
    localparam int DEF_FRAC_BITS   = 16;

    localparam int MAX_EXT_W  = 23;
    localparam int ZOFF_W     = 24;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int SCALE_W    = 32;
    localparam int SENT_UNITS = 100;

    localparam logic [MAX_EXT_W-1:0] MAX_EXT_RESET = MAX_EXT_W'(65536);
    localparam logic [ZOFF_W-1:0]    ZOFF_RESET    = ZOFF_W'(98304);

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_EXTENT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_Z_OFFSET   = CFG_IDX_W'(1);

    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_MEASURE = 2'd1;
    localparam logic [1:0] OP_NORM    = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic clear;
        logic meas;
        logic range_calc;
        logic div_init;
        logic div_step;
        logic div_end;
        logic d2;
        logic mul;
        logic rnd;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic scale_ready;
        logic div_done;
        logic out_free;
    } t_sts;

    // +100.0 clipped to the signed coordinate range
    function automatic longint sent_pos(int cw, int fb);
        longint v;
        longint hi;
        v  = longint'(SENT_UNITS) <<< fb;
        hi = (longint'(1) <<< (cw - 1)) - 1;
        return (v > hi) ? hi : v;
    endfunction

    // -100.0 clipped to the signed coordinate range
    function automatic longint sent_neg(int cw, int fb);
        longint v;
        longint lo;
        v  = -(longint'(SENT_UNITS) <<< fb);
        lo = -(longint'(1) <<< (cw - 1));
        return (v < lo) ? lo : v;
    endfunction

endpackage

[sv/pcbn_in_if.sv]
interface pcbn_in_if
    import pcbn_pkg::*;
#(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    op;
    logic signed [COORD_WIDTH-1:0] in_x;
    logic signed [COORD_WIDTH-1:0] in_y;
    logic signed [COORD_WIDTH-1:0] in_z;

    modport source (output valid, op, in_x, in_y, in_z, input ready);
    modport sink   (input valid, op, in_x, in_y, in_z, output ready);
endinterface

[sv/pcbn_out_if.sv]
interface pcbn_out_if
    import pcbn_pkg::*;
#(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic signed [COORD_WIDTH-1:0] out_z;
    logic                          saturated;

    modport source (output valid, out_x, out_y, out_z, saturated, input ready);
    modport sink   (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface

[sv/pcbn_ctrl.sv]
module pcbn_ctrl
    import pcbn_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_op,
    output logic       o_ready,
    input  t_sts       i_sts,
    output t_cmd       o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_RANGE = 8'b0000_0010,
        S_RMAX  = 8'b0000_0100,
        S_DIV   = 8'b0000_1000,
        S_D2    = 8'b0001_0000,
        S_MUL   = 8'b0010_0000,
        S_RND   = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    case (i_op)
                        OP_CLEAR:   o_cmd.clear = 1'b1;
                        OP_MEASURE: o_cmd.meas  = 1'b1;
                        OP_NORM:    n_state = i_sts.scale_ready ? S_D2 : S_RANGE;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_RANGE: begin
                o_cmd.range_calc = 1'b1;
                n_state = S_RMAX;
            end
            S_RMAX: begin
                o_cmd.div_init = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.div_end = 1'b1;
                    n_state = S_D2;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_D2: begin
                o_cmd.d2 = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_RND;
            end
            S_RND: begin
                o_cmd.rnd = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                // wait here while the previous result is still held
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_ready_skip_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid && i_op == OP_NORM && i_sts.scale_ready)
        |=> r_state == S_D2)
        else $error("normalize with valid scale did not go straight to the datapath");

    a_div_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !i_sts.div_done) |=> r_state == S_DIV)
        else $error("divider left before done");

    a_fin_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && !i_sts.out_free) |=> r_state == S_FIN)
        else $error("result dropped while output register full");

endmodule

[sv/pcbn_dp.sv]
module pcbn_dp
    import pcbn_pkg::*;
#(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
)(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic signed [COORD_WIDTH-1:0] i_x,
    input  logic signed [COORD_WIDTH-1:0] i_y,
    input  logic signed [COORD_WIDTH-1:0] i_z,
    input  t_cmd                          i_cmd,
    output t_sts                          o_sts,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic signed [COORD_WIDTH-1:0] o_out_x,
    output logic signed [COORD_WIDTH-1:0] o_out_y,
    output logic signed [COORD_WIDTH-1:0] o_out_z,
    output logic                          o_saturated
);

    localparam int CW     = COORD_WIDTH;
    localparam int DIV_W  = MAX_EXT_W + FRAC_BITS;
    localparam int CNT_W  = $clog2(DIV_W + 1);
    localparam int D2_W   = CW + 2;
    localparam int PROD_W = D2_W + SCALE_W + 1;
    localparam int Q_W    = PROD_W - FRAC_BITS - 1;
    localparam int SUM_W  = Q_W + 1;

    localparam logic signed [CW-1:0] SENT_P = CW'(sent_pos(CW, FRAC_BITS));
    localparam logic signed [CW-1:0] SENT_N = CW'(sent_neg(CW, FRAC_BITS));
    localparam logic [PROD_W-1:0]    HALF   = PROD_W'(1) << FRAC_BITS;

    logic [MAX_EXT_W-1:0]      r_max_ext;
    logic signed [ZOFF_W-1:0]  r_zoff;

    logic signed [CW-1:0]      r_max [3];
    logic signed [CW-1:0]      r_min [3];
    logic signed [CW-1:0]      r_pt  [3];
    logic [CW-1:0]             r_rng [3];
    logic [CW-1:0]             r_den;
    logic [CW-1:0]             r_rem;
    logic [DIV_W-1:0]          r_quo;
    logic [CNT_W-1:0]          r_cnt;
    logic [SCALE_W-1:0]        r_scale;
    logic                      r_scale_ready;
    logic                      r_range_zero;
    logic signed [D2_W-1:0]    r_d2   [3];
    logic signed [PROD_W-1:0]  r_prod [3];
    logic signed [Q_W-1:0]     r_q    [3];

    logic                      r_out_valid;
    logic signed [CW-1:0]      r_out  [3];
    logic                      r_sat;

    logic signed [CW-1:0]      w_in [3];
    logic [CW-1:0]             w_rng [3];
    logic [CW-1:0]             w_rmax;
    logic [CW:0]               w_shift;
    logic                      w_ge;
    logic [63:0]               w_quo_ext;
    logic signed [D2_W-1:0]    w_d2 [3];
    logic [PROD_W-1:0]         w_rnd [3];
    logic signed [SUM_W-1:0]   w_sum [3];
    logic signed [CW-1:0]      w_clip [3];
    logic [2:0]                w_ovf;

    assign w_in[0] = i_x;
    assign w_in[1] = i_y;
    assign w_in[2] = i_z;

    always_comb begin
        logic [CW:0] diff_ab;
        logic [CW:0] diff_ba;
        for (int i = 0; i < 3; i++) begin
            diff_ab = {r_max[i][CW-1], r_max[i]} - {r_min[i][CW-1], r_min[i]};
            diff_ba = {r_min[i][CW-1], r_min[i]} - {r_max[i][CW-1], r_max[i]};
            w_rng[i] = diff_ab[CW] ? diff_ba[CW-1:0] : diff_ab[CW-1:0];
        end
    end

    always_comb begin
        w_rmax = r_rng[0];
        if (r_rng[1] > w_rmax) w_rmax = r_rng[1];
        if (r_rng[2] > w_rmax) w_rmax = r_rng[2];
    end

    // restoring divider, one quotient bit a cycle
    assign w_shift   = {r_rem, r_quo[DIV_W-1]};
    assign w_ge      = w_shift >= {1'b0, r_den};
    assign w_quo_ext = 64'(r_quo);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_d2[i] = {r_pt[i][CW-1], r_pt[i], 1'b0}
                      - ({{2{r_max[i][CW-1]}}, r_max[i]} + {{2{r_min[i][CW-1]}}, r_min[i]});
            // halves away from zero: negative values round up from half minus one
            w_rnd[i] = r_prod[i] + HALF - PROD_W'(r_prod[i][PROD_W-1]);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sum[i] = {r_q[i][Q_W-1], r_q[i]};
        end
        w_sum[2] = w_sum[2] + {{(SUM_W-ZOFF_W){r_zoff[ZOFF_W-1]}}, r_zoff};
        for (int i = 0; i < 3; i++) begin
            w_ovf[i] = !((&w_sum[i][SUM_W-1:CW-1]) || !(|w_sum[i][SUM_W-1:CW-1]));
            if (w_ovf[i]) begin
                w_clip[i] = w_sum[i][SUM_W-1] ? {1'b1, {(CW-1){1'b0}}}
                                              : {1'b0, {(CW-1){1'b1}}};
            end else begin
                w_clip[i] = w_sum[i][CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_ext <= MAX_EXT_RESET;
            r_zoff    <= ZOFF_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_EXTENT: r_max_ext <= i_cfg_data[MAX_EXT_W-1:0];
                CFG_Z_OFFSET:   r_zoff    <= i_cfg_data[ZOFF_W-1:0];
                default:        r_max_ext <= r_max_ext;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_max[i] <= SENT_N;
                r_min[i] <= SENT_P;
            end
            r_scale       <= '0;
            r_scale_ready <= 1'b0;
            r_range_zero  <= 1'b0;
            r_cnt         <= '0;
        end else begin
            if (i_cmd.clear) begin
                for (int i = 0; i < 3; i++) begin
                    r_max[i] <= SENT_N;
                    r_min[i] <= SENT_P;
                end
                r_scale_ready <= 1'b0;
                r_range_zero  <= 1'b0;
            end
            if (i_cmd.meas) begin
                for (int i = 0; i < 3; i++) begin
                    if (w_in[i] > r_max[i]) r_max[i] <= w_in[i];
                    if (w_in[i] < r_min[i]) r_min[i] <= w_in[i];
                end
                r_scale_ready <= 1'b0;
            end
            if (i_cmd.div_init) begin
                r_cnt <= CNT_W'(DIV_W);
            end
            if (i_cmd.div_step) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
            if (i_cmd.div_end) begin
                if (r_den == '0) begin
                    r_scale      <= '1;
                    r_range_zero <= 1'b1;
                end else begin
                    r_scale      <= (|w_quo_ext[63:SCALE_W]) ? '1 : w_quo_ext[SCALE_W-1:0];
                    r_range_zero <= 1'b0;
                end
                r_scale_ready <= 1'b1;
            end
        end
    end

    // datapath registers without reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            for (int i = 0; i < 3; i++) r_pt[i] <= w_in[i];
        end
        if (i_cmd.range_calc) begin
            for (int i = 0; i < 3; i++) r_rng[i] <= w_rng[i];
        end
        if (i_cmd.div_init) begin
            r_den <= w_rmax;
            r_rem <= '0;
            r_quo <= {r_max_ext, {FRAC_BITS{1'b0}}};
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? CW'(w_shift - {1'b0, r_den}) : w_shift[CW-1:0];
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
        end
        if (i_cmd.d2) begin
            for (int i = 0; i < 3; i++) r_d2[i] <= w_d2[i];
        end
        if (i_cmd.mul) begin
            for (int i = 0; i < 3; i++) r_prod[i] <= r_d2[i] * $signed({1'b0, r_scale});
        end
        if (i_cmd.rnd) begin
            for (int i = 0; i < 3; i++) r_q[i] <= w_rnd[i][PROD_W-1:FRAC_BITS+1];
        end
        if (i_cmd.fin) begin
            for (int i = 0; i < 3; i++) r_out[i] <= w_clip[i];
            r_sat <= (|w_ovf) || r_range_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.scale_ready = r_scale_ready;
    assign o_sts.div_done    = (r_cnt == '0);
    assign o_sts.out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_x     = r_out[0];
    assign o_out_y     = r_out[1];
    assign o_out_z     = r_out[2];
    assign o_saturated = r_sat;

    a_zero_range_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_range_zero |-> (r_scale == '1))
        else $error("zero range without full scale");

    a_scale_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.div_end && !i_cmd.clear && !i_cmd.meas) |=> r_scale_ready)
        else $error("scale not marked valid after division");

    a_bounds_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.meas |=> (r_max[0] >= r_min[0] && r_max[1] >= r_min[1]
                        && r_max[2] >= r_min[2]))
        else $error("bounds out of order after measuring");

endmodule

[sv/point_cloud_bbox_normalize.sv]
// point cloud bounding box normalizer
// i_pt carries one beat per op: op 0 resets the bounds to the sentinels,
// op 1 folds the point into the per-axis min and max, op 2 normalizes it
// and op 3 is dropped. only op 2 produces a beat on o_res.
// configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data
// (index 0 max_extent, index 1 z_offset); the user must write it only while
// the block is idle, and the block itself does not enforce this. op 0 and
// op 1 act on accept; after an op 2 beat, the next beat is accepted only
// once the block is idle again. the first op 2 after a clear or measure
// derives the scale: range, max, a restoring divider at one quotient bit
// a cycle for 23 + FRAC_BITS steps, then write-back.
// per-point work is set by the d2 / multiply / round / clip steps that
// share one datapath.
// the result sits in an output register; a stalled receiver leaves it held
// and the block still takes the next beat, stopping at the final step only
// while the register is full.
// synchronous reset restores register defaults, the sentinel bounds and a
// zero scale, and empties the output register.
module point_cloud_bbox_normalize
    import pcbn_pkg::*;
#(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    pcbn_in_if.sink               i_pt,
    pcbn_out_if.source            o_res
);

    t_cmd w_cmd;
    t_sts w_sts;

    pcbn_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_pt.valid),
        .i_op    (i_pt.op),
        .o_ready (i_pt.ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    pcbn_dp #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_x         (i_pt.in_x),
        .i_y         (i_pt.in_y),
        .i_z         (i_pt.in_z),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_out_x     (o_res.out_x),
        .o_out_y     (o_res.out_y),
        .o_out_z     (o_res.out_z),
        .o_saturated (o_res.saturated)
    );

endmodule
